[rtl/vfd_gate_scan_framebuffer_top_macros.svh]
// Assertion macros shared by the frame buffer checker.
`ifndef VFD_GATE_SCAN_FRAMEBUFFER_TOP_MACROS_SVH
`define VFD_GATE_SCAN_FRAMEBUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VGSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VGSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vgsf_pkg.sv]
// Types and constants shared by the gate-scanned display frame buffer.
package vgsf_pkg;

    // Item functions
    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_SWAP  = 2'd2;
    localparam logic [1:0] FUNC_GATE  = 2'd3;

    localparam int         GROUP_BYTES = 48;
    localparam int         GATE_COUNT  = 44;
    localparam logic [5:0] SKEW_RESET  = 6'd8;
    localparam logic [7:0] MASK_EVEN   = 8'h55;
    localparam logic [7:0] MASK_ODD    = 8'hAA;
    localparam logic [7:0] PIXEL_MSB   = 8'h80;
    localparam logic [7:0] FILL_ONES   = 8'hFF;

    // x/6 for 8-bit x as (x*171) >> 10
    localparam int DIV6_MUL   = 171;
    localparam int DIV6_SHIFT = 10;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pixel_x;
        logic [6:0] pixel_y;
        logic       pixel_on;
    } t_in_item;

    typedef struct packed {
        logic [7:0] anode_byte;
        logic       gate_serial;
        logic [5:0] gate_number;
        logic       last_of_gate;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic fill_init;
        logic sweep_wr;
        logic pix_rd;
        logic pix_wr;
        logic swap;
        logic gs_init;
        logic gs_reduce;
        logic gs_rd;
        logic gs_next;
        logic gs_done;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       pixel_ok;
        logic       sweep_last;
        logic       start_ge;
        logic       byte_last;
    } t_dp_stat;

endpackage

[rtl/vgsf_ctrl.sv]
// Sequencer for the frame buffer: decodes items and steps the datapath.
module vgsf_ctrl import vgsf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_PIX_RD = 4'd3;
    localparam logic [3:0] S_PIX_WR = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_GS_MOD = 4'd6;
    localparam logic [3:0] S_GS_RD  = 4'd7;
    localparam logic [3:0] S_GS_OUT = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_GS_OUT);

    // Decode next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.func)
                    FUNC_PIXEL: begin
                        n_state = i_stat.pixel_ok ? S_PIX_RD : S_IDLE;
                    end
                    FUNC_FILL: begin
                        o_cmd.fill_init = 1'b1;
                        n_state         = S_FILL;
                    end
                    FUNC_SWAP: begin
                        o_cmd.swap = 1'b1;
                        n_state    = S_IDLE;
                    end
                    FUNC_GATE: begin
                        o_cmd.gs_init = 1'b1;
                        n_state       = S_GS_MOD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_PIX_RD: begin
                o_cmd.pix_rd = 1'b1;
                n_state      = S_PIX_WR;
            end
            S_PIX_WR: begin
                o_cmd.pix_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_FILL: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_GS_MOD: begin
                if (i_stat.start_ge) begin
                    o_cmd.gs_reduce = 1'b1;
                end else begin
                    n_state = S_GS_RD;
                end
            end
            S_GS_RD: begin
                o_cmd.gs_rd = 1'b1;
                n_state     = S_GS_OUT;
            end
            S_GS_OUT: begin
                if (i_out_ready) begin
                    if (i_stat.byte_last) begin
                        o_cmd.gs_done = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.gs_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/vgsf_datapath.sv]
// Frame store, address arithmetic and output formatting for the frame buffer.
module vgsf_datapath import vgsf_pkg::*; #(
    parameter int COLUMN_GROUPS  = 22,
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  logic      i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out_data
);

    localparam int FRAME_BYTES = COLUMN_GROUPS * GROUP_BYTES;
    localparam int STORE_BYTES = 2 * FRAME_BYTES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int PW          = AW + 1;
    localparam int START_MAX   = FRAME_BYTES + (GATE_COUNT / 2) * GROUP_BYTES + STORE_BYTES;
    localparam int SW          = $clog2(START_MAX + 1);

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rdata;
    t_in_item      r_item;
    logic [5:0]    r_skew;
    logic          r_sel;
    logic [5:0]    r_gate;
    logic [AW-1:0] r_sweep;
    logic [AW-1:0] r_sweep_end;
    logic [7:0]    r_fill_byte;
    logic [SW-1:0] r_gaddr;
    logic [5:0]    r_bidx;

    logic [15:0]   x_prod;
    logic [5:0]    group;
    logic [7:0]    g6;
    logic [2:0]    xmod;
    logic [8:0]    bitn;
    logic [7:0]    pix_mask;
    logic [PW-1:0] pix_sum;
    logic [AW-1:0] pix_addr;
    logic          pixel_ok;
    logic [5:0]    gate_eff;
    logic [SW-1:0] start_sum;
    logic [7:0]    pix_wdata;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [7:0]    mem_wd;

    // Pixel address: group = x/6, bit = y*6 + x%6, byte = bit/8
    assign x_prod   = 16'(r_item.pixel_x) * 16'(DIV6_MUL);
    assign group    = x_prod[DIV6_SHIFT +: 6];
    assign g6       = {2'b00, group} * 8'd6;
    assign xmod     = 3'(r_item.pixel_x - g6);
    assign bitn     = {3'b000, r_item.pixel_y[5:0]} * 9'd6 + {6'b000000, xmod};
    assign pix_mask = PIXEL_MSB >> bitn[2:0];
    assign pix_sum  = (r_sel ? PW'(FRAME_BYTES) : '0)
                    + PW'(group) * PW'(GROUP_BYTES) + PW'(bitn[8:3]);
    assign pix_addr = pix_sum[AW-1:0];
    assign pixel_ok = ({1'b0, r_item.pixel_x} < 9'(DISPLAY_WIDTH))
                   && ({1'b0, r_item.pixel_y} < 8'(DISPLAY_HEIGHT))
                   && ({1'b0, group} < 7'(COLUMN_GROUPS));
    assign pix_wdata = r_item.pixel_on ? (r_rdata | pix_mask) : (r_rdata & ~pix_mask);

    // Gate start: display base + (gate/2)*48 - skew, offset by one store to stay positive
    assign gate_eff  = (r_gate < 6'(GATE_COUNT)) ? r_gate : 6'd0;
    assign start_sum = (r_sel ? '0 : SW'(FRAME_BYTES))
                     + SW'(gate_eff[5:1]) * SW'(GROUP_BYTES)
                     + SW'(STORE_BYTES) - SW'(r_skew);

    // Memory port selection
    assign mem_we = i_cmd.sweep_wr | i_cmd.pix_wr;
    assign mem_wa = i_cmd.sweep_wr ? r_sweep : pix_addr;
    assign mem_wd = i_cmd.sweep_wr ? r_fill_byte : pix_wdata;
    assign mem_re = i_cmd.pix_rd | i_cmd.gs_rd | i_cmd.gs_next;
    assign mem_ra = i_cmd.pix_rd ? pix_addr : r_gaddr[AW-1:0];

    // Frame store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
    end

    // Hold skew, frame select and gate counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skew <= SKEW_RESET;
            r_sel  <= 1'b0;
            r_gate <= '0;
        end else begin
            if (i_cfg_we) begin
                r_skew <= i_cfg_data;
            end
            if (i_cmd.swap) begin
                r_sel <= ~r_sel;
            end
            if (i_cmd.gs_done) begin
                r_gate <= (gate_eff == 6'(GATE_COUNT - 1)) ? 6'd0 : gate_eff + 6'd1;
            end
        end
    end

    // Advance the sweep used by the reset clear and by fills
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_sweep_end <= AW'(STORE_BYTES - 1);
            r_fill_byte <= '0;
        end else if (i_cmd.fill_init) begin
            r_sweep     <= r_sel ? AW'(FRAME_BYTES) : '0;
            r_sweep_end <= r_sel ? AW'(STORE_BYTES - 1) : AW'(FRAME_BYTES - 1);
            r_fill_byte <= r_item.pixel_on ? FILL_ONES : 8'h00;
        end else if (i_cmd.sweep_wr) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    // Walk the gate read address, wrapping at the store end
    always_ff @(posedge i_clk) begin
        if (i_cmd.gs_init) begin
            r_gaddr <= start_sum;
        end else if (i_cmd.gs_reduce) begin
            r_gaddr <= r_gaddr - SW'(STORE_BYTES);
        end else if (i_cmd.gs_rd || i_cmd.gs_next) begin
            r_gaddr <= (r_gaddr == SW'(STORE_BYTES - 1)) ? '0 : r_gaddr + SW'(1);
        end
    end

    // Count bytes of the current gate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bidx <= '0;
        end else if (i_cmd.gs_rd) begin
            r_bidx <= '0;
        end else if (i_cmd.gs_next) begin
            r_bidx <= r_bidx + 6'd1;
        end
    end

    assign o_stat.func       = r_item.func;
    assign o_stat.pixel_ok   = pixel_ok;
    assign o_stat.sweep_last = (r_sweep == r_sweep_end);
    assign o_stat.start_ge   = (r_gaddr >= SW'(STORE_BYTES));
    assign o_stat.byte_last  = (r_bidx == 6'(GROUP_BYTES - 1));

    assign o_out_data.anode_byte   = r_rdata & (gate_eff[0] ? MASK_ODD : MASK_EVEN);
    assign o_out_data.gate_serial  = (gate_eff < 6'd2);
    assign o_out_data.gate_number  = gate_eff;
    assign o_out_data.last_of_gate = o_stat.byte_last;

endmodule

[rtl/vfd_gate_scan_framebuffer_top.sv]
// Top level of the double-buffered frame store and gate refresh sequencer.
// Items are taken one at a time. After reset the whole store is cleared one
// byte per cycle before the first item is accepted. After the accept, a swap
// toggles the frame select in the decode step, a pixel write within the
// display reads the byte and writes it back with the pixel bit changed
// (read-modify-write on the store), a fill writes every byte of the frame
// selected for writing (one byte written per cycle), and a gate step brings
// its start address back into the store when it lies past the store end,
// reads the first byte, then sends the gate's bytes while the output is ready.
// The read skew register may be written at any time the block is idle.
module vfd_gate_scan_framebuffer_top import vgsf_pkg::*; #(
    parameter int COLUMN_GROUPS  = 22,
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    vgsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    vgsf_datapath #(
        .COLUMN_GROUPS  (COLUMN_GROUPS),
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

[rtl/vgsf_checker.sv]
// Port-level checks on the frame buffer top level, with their bind.
`include "vfd_gate_scan_framebuffer_top_macros.svh"

module vgsf_checker import vgsf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Items are worked one at a time: no intake while a byte is offered
    `VGSF_ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, o_out_valid, !o_in_ready, "intake during output")

    // A byte run streams: a non-final transaction is followed by another byte
    `VGSF_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_data.last_of_gate, o_out_valid && $stable(o_out_data.gate_number), "byte run broken")

    // The final byte of a gate ends the run
    `VGSF_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, o_out_valid && i_out_ready && o_out_data.last_of_gate, !o_out_valid, "output after last byte")

    // Stalled output holds its transaction
    `VGSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled output changed")

endmodule

bind vfd_gate_scan_framebuffer_top vgsf_checker u_vgsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
